FILE: rtl/u2l_pkg.sv
// Shared types, byte codes and the letter table for the UTF-8 Cyrillic to Latin block.
package u2l_pkg;

    // Input item: one byte of UTF-8 text
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    // Output item: one Latin character
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } out_item_t;

    // Pending lead byte, one-hot
    typedef enum logic [2:0] {
        LEAD_NONE = 3'b001,
        LEAD_D0   = 3'b010,
        LEAD_D1   = 3'b100
    } lead_t;

    // Run of up to three characters produced by one byte; chars[0] goes first
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      cnt;
    } run_t;

    localparam logic [7:0] BYTE_D0     = 8'hD0;
    localparam logic [7:0] BYTE_D1     = 8'hD1;
    localparam logic [7:0] BYTE_YO_UP  = 8'h81;  // D0 81: capital Yo
    localparam logic [7:0] BYTE_YO_LO  = 8'h91;  // D1 91: small yo
    localparam logic [7:0] D0_FIRST    = 8'h90;
    localparam logic [7:0] D0_LAST     = 8'hBF;
    localparam logic [3:0] D1_HI_NIB   = 4'h8;   // D1 80..8F
    localparam logic [5:0] D0_SLOT_OFS = 6'h10;
    localparam logic [7:0] CHAR_SP     = 8'h20;
    localparam logic [7:0] CHAR_UY     = 8'h59;  // 'Y'
    localparam logic [7:0] CHAR_LY     = 8'h79;  // 'y'
    localparam logic [7:0] CHAR_LO     = 8'h6F;  // 'o'
    localparam logic [23:0] LOWER_MASK = 24'h202020;

    // Capital letter text, first character in the top byte, padded with spaces
    function automatic logic [23:0] upper_text(input logic [4:0] idx);
        logic [23:0] t;
        case (idx)
            5'd0:    t = "A  ";
            5'd1:    t = "B  ";
            5'd2:    t = "V  ";
            5'd3:    t = "G  ";
            5'd4:    t = "D  ";
            5'd5:    t = "E  ";
            5'd6:    t = "Zh ";
            5'd7:    t = "Z  ";
            5'd8:    t = "I  ";
            5'd9:    t = "Y  ";
            5'd10:   t = "K  ";
            5'd11:   t = "L  ";
            5'd12:   t = "M  ";
            5'd13:   t = "N  ";
            5'd14:   t = "O  ";
            5'd15:   t = "P  ";
            5'd16:   t = "R  ";
            5'd17:   t = "S  ";
            5'd18:   t = "T  ";
            5'd19:   t = "U  ";
            5'd20:   t = "F  ";
            5'd21:   t = "Kh ";
            5'd22:   t = "Ts ";
            5'd23:   t = "Ch ";
            5'd24:   t = "Sh ";
            5'd25:   t = "Sch";
            5'd26:   t = "   ";
            5'd27:   t = "Y  ";
            5'd28:   t = "   ";
            5'd29:   t = "E  ";
            5'd30:   t = "Yu ";
            5'd31:   t = "Ya ";
            default: t = "   ";
        endcase
        return t;
    endfunction

    // Full 64-slot table; the small letters are the capitals with the case bit set
    function automatic logic [23:0] slot_text(input logic [5:0] slot);
        logic [23:0] t;
        t = upper_text(slot[4:0]);
        if (slot[5])
        begin
            t = t | LOWER_MASK;
        end
        return t;
    endfunction

endpackage

FILE: rtl/u2l_stream_if.sv
// Valid/ready stream interface carrying one payload item per handshake.
interface u2l_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/utf8_cyrillic_to_latin_top.sv
// Top level of the UTF-8 Cyrillic to Latin transliterator.
// Takes one UTF-8 byte per item and gives 0 to 3 Latin characters per byte, with
// run_last marking the last character of each byte's run. A byte is accepted in
// every cycle while the output keeps up: a byte enters an input register, is
// decoded into a run register once that register is free, and the run register
// sends one character per cycle while the output is ready. A byte that yields
// two or three characters holds the run register until all have gone out, and
// input accepts stop once the input register is also full. A lead byte 0xD0 or
// 0xD1 gives no output until the next byte; a lead byte flagged end of text goes
// out raw, and an unknown byte after a lead goes out raw together with the lead.
module utf8_cyrillic_to_latin_top (
    input  logic                clk,
    input  logic                rst_n,
    u2l_stream_if.sink          byte_in,
    u2l_stream_if.source        char_out
);

    u2l_pkg::lead_t  lead_reg, lead_next;

    logic            inq_v_reg, inq_v_next;
    u2l_pkg::lead_t  inq_lead_reg;
    logic [7:0]      inq_byte_reg;
    logic            inq_eot_reg;

    logic            res_v_reg, res_v_next;
    logic [2:0][7:0] res_chars_reg;
    logic [1:0]      res_cnt_reg;
    logic [1:0]      res_idx_reg, res_idx_next;

    u2l_pkg::run_t   dec_run;
    logic            accept;
    logic            out_fire;
    logic            is_last;
    logic            res_free;
    logic            move;
    logic [7:0]      cur_char;

    // Handshake
    assign is_last  = (res_idx_reg == (res_cnt_reg - 2'd1));
    assign out_fire = res_v_reg && char_out.ready;
    assign res_free = !res_v_reg || (char_out.ready && is_last);
    assign move     = inq_v_reg && res_free;
    assign byte_in.ready = !inq_v_reg || res_free;
    assign accept   = byte_in.valid && byte_in.ready;

    // Pending lead tracking
    always_comb
    begin
        lead_next = lead_reg;
        if (accept)
        begin
            if (lead_reg != u2l_pkg::LEAD_NONE)
            begin
                lead_next = u2l_pkg::LEAD_NONE;
            end
            else if (byte_in.payload.data_byte == u2l_pkg::BYTE_D0
                     && !byte_in.payload.end_of_text)
            begin
                lead_next = u2l_pkg::LEAD_D0;
            end
            else if (byte_in.payload.data_byte == u2l_pkg::BYTE_D1
                     && !byte_in.payload.end_of_text)
            begin
                lead_next = u2l_pkg::LEAD_D1;
            end
            else
            begin
                lead_next = u2l_pkg::LEAD_NONE;
            end
        end
    end

    // Input register valid
    always_comb
    begin
        inq_v_next = inq_v_reg;
        if (accept)
        begin
            inq_v_next = 1'b1;
        end
        else if (move)
        begin
            inq_v_next = 1'b0;
        end
    end

    u2l_decode u_decode (
        .lead        (inq_lead_reg),
        .data_byte   (inq_byte_reg),
        .end_of_text (inq_eot_reg),
        .run         (dec_run)
    );

    // Run register control
    always_comb
    begin
        res_v_next   = res_v_reg;
        res_idx_next = res_idx_reg;
        if (move)
        begin
            res_v_next   = (dec_run.cnt != 2'd0);
            res_idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                res_v_next = 1'b0;
            end
            else
            begin
                res_idx_next = res_idx_reg + 2'd1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= u2l_pkg::LEAD_NONE;
            inq_v_reg   <= 1'b0;
            res_v_reg   <= 1'b0;
            res_idx_reg <= 2'd0;
        end
        else
        begin
            lead_reg    <= lead_next;
            inq_v_reg   <= inq_v_next;
            res_v_reg   <= res_v_next;
            res_idx_reg <= res_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inq_lead_reg <= lead_reg;
            inq_byte_reg <= byte_in.payload.data_byte;
            inq_eot_reg  <= byte_in.payload.end_of_text;
        end
        if (move)
        begin
            res_chars_reg <= dec_run.chars;
            res_cnt_reg   <= dec_run.cnt;
        end
    end

    // Output select
    always_comb
    begin
        case (res_idx_reg)
            2'd0:    cur_char = res_chars_reg[0];
            2'd1:    cur_char = res_chars_reg[1];
            2'd2:    cur_char = res_chars_reg[2];
            default: cur_char = res_chars_reg[0];
        endcase
    end

    assign char_out.valid            = res_v_reg;
    assign char_out.payload.out_char = cur_char;
    assign char_out.payload.run_last = is_last;

endmodule

FILE: rtl/u2l_decode.sv
// Decoder: turns a byte and its pending lead into a run of output characters.
module u2l_decode (
    input  u2l_pkg::lead_t lead,
    input  logic [7:0]     data_byte,
    input  logic           end_of_text,
    output u2l_pkg::run_t  run
);

    logic [23:0] text;
    logic [5:0]  slot;
    logic        in_table;

    // Table slot select
    always_comb
    begin
        slot     = '0;
        in_table = 1'b0;
        case (lead)
            u2l_pkg::LEAD_D0:
            begin
                in_table = (data_byte >= u2l_pkg::D0_FIRST) && (data_byte <= u2l_pkg::D0_LAST);
                slot     = data_byte[5:0] - u2l_pkg::D0_SLOT_OFS;
            end
            u2l_pkg::LEAD_D1:
            begin
                in_table = (data_byte[7:4] == u2l_pkg::D1_HI_NIB);
                slot     = {2'b11, data_byte[3:0]};
            end
            default:
            begin
                in_table = 1'b0;
                slot     = '0;
            end
        endcase
    end

    assign text = u2l_pkg::slot_text(slot);

    // Build the run
    always_comb
    begin
        run = '0;
        case (lead)
            u2l_pkg::LEAD_D0, u2l_pkg::LEAD_D1:
            begin
                if (lead == u2l_pkg::LEAD_D0 && data_byte == u2l_pkg::BYTE_YO_UP)
                begin
                    run.chars[0] = u2l_pkg::CHAR_UY;
                    run.chars[1] = u2l_pkg::CHAR_LO;
                    run.cnt      = 2'd2;
                end
                else if (lead == u2l_pkg::LEAD_D1 && data_byte == u2l_pkg::BYTE_YO_LO)
                begin
                    run.chars[0] = u2l_pkg::CHAR_LY;
                    run.chars[1] = u2l_pkg::CHAR_LO;
                    run.cnt      = 2'd2;
                end
                else if (in_table)
                begin
                    run.chars[0] = text[23:16];
                    run.chars[1] = text[15:8];
                    run.chars[2] = text[7:0];
                    // spaces only pad the tail of an entry
                    if (text[23:16] == u2l_pkg::CHAR_SP)
                    begin
                        run.cnt = 2'd0;
                    end
                    else if (text[15:8] == u2l_pkg::CHAR_SP)
                    begin
                        run.cnt = 2'd1;
                    end
                    else if (text[7:0] == u2l_pkg::CHAR_SP)
                    begin
                        run.cnt = 2'd2;
                    end
                    else
                    begin
                        run.cnt = 2'd3;
                    end
                end
                else
                begin
                    // not a known letter: lead and byte go out raw
                    run.chars[0] = (lead == u2l_pkg::LEAD_D0) ? u2l_pkg::BYTE_D0
                                                               : u2l_pkg::BYTE_D1;
                    run.chars[1] = data_byte;
                    run.cnt      = 2'd2;
                end
            end
            default:
            begin
                run.chars[0] = data_byte;
                if ((data_byte == u2l_pkg::BYTE_D0 || data_byte == u2l_pkg::BYTE_D1)
                    && !end_of_text)
                begin
                    run.cnt = 2'd0;   // lead byte is held, nothing yet
                end
                else
                begin
                    run.cnt = 2'd1;
                end
            end
        endcase
    end

endmodule

FILE: rtl/u2l_checker.sv
// Port-level checker for the transliterator top level, with its bind.
module u2l_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input u2l_pkg::out_item_t  out_payload
);

    // Nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // With no character waiting, input must be open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Only Latin letters or a raw lead byte can come before the last character of a run
    a_mid_run_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_payload.run_last) |->
            (out_payload.out_char[7] == 1'b0 || out_payload.out_char == u2l_pkg::BYTE_D0
             || out_payload.out_char == u2l_pkg::BYTE_D1))
        else $error("unexpected character inside a run");

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
        else $error("output item changed while stalled");

endmodule

bind utf8_cyrillic_to_latin_top u2l_checker u_u2l_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (byte_in.ready),
    .out_valid   (char_out.valid),
    .out_ready   (char_out.ready),
    .out_payload (char_out.payload)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 Cyrillic to Latin transliterator.
module testbench;

    localparam logic [7:0] CYR_D0       = u2l_pkg::BYTE_D0;
    localparam logic [7:0] CYR_D1       = u2l_pkg::BYTE_D1;
    localparam logic [7:0] TAIL_YO_CAP  = u2l_pkg::BYTE_YO_UP;
    localparam logic [7:0] TAIL_YO_SML  = u2l_pkg::BYTE_YO_LO;
    localparam logic [7:0] TAIL_D0_LO   = u2l_pkg::D0_FIRST;
    localparam logic [7:0] TAIL_D0_HI   = u2l_pkg::D0_LAST;
    localparam logic [7:0] TAIL_D1_LO   = 8'h80;
    localparam logic [7:0] TAIL_D1_HI   = 8'h8F;
    localparam logic [7:0] TAIL_HARD    = 8'hAA;   // capital hard sign after D0
    localparam logic [7:0] TAIL_SOFT    = 8'h8C;   // small soft sign after D1
    localparam logic [7:0] TAIL_SHCH    = 8'hA9;   // capital shcha after D0
    localparam logic [7:0] ASCII_SPACE  = u2l_pkg::CHAR_SP;
    localparam int         RANDOM_ITEMS = 410;
    localparam int         DRAIN_SLACK  = 8;

    // Capital letters, slot 0 in the top 24 bits, padded with spaces
    localparam logic [767:0] CAPITALS = {
        "A  ", "B  ", "V  ", "G  ", "D  ", "E  ", "Zh ", "Z  ",
        "I  ", "Y  ", "K  ", "L  ", "M  ", "N  ", "O  ", "P  ",
        "R  ", "S  ", "T  ", "U  ", "F  ", "Kh ", "Ts ", "Ch ",
        "Sh ", "Sch", "   ", "Y  ", "   ", "E  ", "Yu ", "Ya "
    };

    logic clk;
    logic rst_n;

    u2l_stream_if #(.payload_t(u2l_pkg::in_item_t))  byte_if ();
    u2l_stream_if #(.payload_t(u2l_pkg::out_item_t)) char_if ();

    utf8_cyrillic_to_latin_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_if),
        .char_out (char_if)
    );

    u2l_pkg::out_item_t expected_chars [$];
    u2l_pkg::lead_t     lead_state;
    int                 error_count;
    int                 burst_left;
    bit                 gaps_on;
    int                 hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1_600_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Text of one table slot; small letters are the capitals shifted to lower case
    function automatic logic [23:0] letter_text(input int slot);
        logic [23:0] txt;
        int          k;
        txt = CAPITALS[767 - 24 * (slot % 32) -: 24];
        if (slot >= 32)
        begin
            for (k = 0; k < 3; k++)
            begin
                if (txt[8*k +: 8] >= "A" && txt[8*k +: 8] <= "Z")
                begin
                    txt[8*k +: 8] = txt[8*k +: 8] + 8'd32;
                end
            end
        end
        return txt;
    endfunction

    // Expected characters for one accepted byte; updates the pending lead
    function automatic void predict_chars(input logic [7:0] b, input logic eot);
        logic [7:0]     run [3];
        logic [7:0]     lead_byte;
        logic [7:0]     c;
        logic [23:0]    txt;
        u2l_pkg::lead_t lead;
        int             n;
        int             slot;
        int             k;
        n = 0;
        slot = -1;
        lead = lead_state;
        lead_state = u2l_pkg::LEAD_NONE;
        if (lead == u2l_pkg::LEAD_D0 || lead == u2l_pkg::LEAD_D1)
        begin
            lead_byte = (lead == u2l_pkg::LEAD_D0) ? CYR_D0 : CYR_D1;
            if (lead == u2l_pkg::LEAD_D0 && b == TAIL_YO_CAP)
            begin
                run[0] = "Y";
                run[1] = "o";
                n = 2;
            end
            else if (lead == u2l_pkg::LEAD_D1 && b == TAIL_YO_SML)
            begin
                run[0] = "y";
                run[1] = "o";
                n = 2;
            end
            else
            begin
                if (lead == u2l_pkg::LEAD_D0 && b >= TAIL_D0_LO && b <= TAIL_D0_HI)
                    slot = int'(b - TAIL_D0_LO);
                else if (lead == u2l_pkg::LEAD_D1 && b >= TAIL_D1_LO && b <= TAIL_D1_HI)
                    slot = 48 + int'(b - TAIL_D1_LO);
                if (slot < 0)
                begin
                    // not a table entry: lead and byte go out raw
                    run[0] = lead_byte;
                    run[1] = b;
                    n = 2;
                end
                else
                begin
                    txt = letter_text(slot);
                    for (k = 0; k < 3; k++)
                    begin
                        c = txt[23 - 8*k -: 8];
                        if (c != ASCII_SPACE)
                        begin
                            run[n] = c;
                            n++;
                        end
                    end
                end
            end
        end
        else if (b == CYR_D0 || b == CYR_D1)
        begin
            if (eot)
            begin
                run[0] = b;
                n = 1;
            end
            else
            begin
                lead_state = (b == CYR_D0) ? u2l_pkg::LEAD_D0 : u2l_pkg::LEAD_D1;
            end
        end
        else
        begin
            run[0] = b;
            n = 1;
        end
        for (k = 0; k < n; k++)
        begin
            expected_chars.push_back('{out_char: run[k], run_last: (k == n - 1)});
        end
    endfunction

    // Offer one byte until accepted, then maybe take a gap
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        byte_if.valid   <= 1'b1;
        byte_if.payload <= '{data_byte: b, end_of_text: eot};
        @(posedge clk);
        while (!byte_if.ready)
        begin
            @(posedge clk);
        end
        predict_chars(b, eot);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 6);
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Sender pauses until every expected character is back
    task automatic wait_drain();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Receiver: random ready pattern, or a long hold-off on request
    initial
    begin
        logic [7:0] stall_bits;
        int         pattern_age;
        int         hold_left;
        char_if.ready = 1'b0;
        stall_bits = 8'hFF;
        pattern_age = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_if.ready <= 1'b0;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        stall_bits = 8'hFF;
                    else
                        stall_bits = 8'($urandom_range(1, 255));
                    pattern_age = $urandom_range(16, 80);
                end
                pattern_age--;
                char_if.ready <= stall_bits[0];
                stall_bits = {stall_bits[0], stall_bits[7:1]};
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        u2l_pkg::out_item_t want;
        if (rst_n && char_if.valid && char_if.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h", char_if.payload.out_char));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_if.payload.out_char !== want.out_char)
                    report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                              char_if.payload.out_char, want.out_char));
                if (char_if.payload.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b on char 0x%02h",
                                              char_if.payload.run_last, want.run_last,
                                              want.out_char));
            end
        end
    end

    task automatic test_passthrough();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte("A", 1'b0);
    endtask

    task automatic test_letters();
        send_byte(CYR_D0, 1'b0);
        send_byte(TAIL_YO_CAP, 1'b0);
        send_byte(CYR_D1, 1'b0);
        send_byte(TAIL_YO_SML, 1'b0);
        send_byte(CYR_D0, 1'b0);
        send_byte(TAIL_D0_LO, 1'b0);
        send_byte(CYR_D0, 1'b0);
        send_byte(TAIL_D0_HI, 1'b0);
        send_byte(CYR_D1, 1'b0);
        send_byte(TAIL_D1_LO, 1'b0);
        send_byte(CYR_D0, 1'b0);
        send_byte(TAIL_SHCH, 1'b0);
    endtask

    // Hard and soft signs give nothing
    task automatic test_signs();
        send_byte(CYR_D0, 1'b0);
        send_byte(TAIL_HARD, 1'b0);
        send_byte(CYR_D1, 1'b0);
        send_byte(TAIL_SOFT, 1'b0);
    endtask

    // Bad continuation, second lead, lead at end of text, end after a lead
    task automatic test_raw_cases();
        send_byte(CYR_D0, 1'b0);
        send_byte("A", 1'b0);
        send_byte(CYR_D1, 1'b0);
        send_byte(CYR_D0, 1'b0);
        send_byte(CYR_D0, 1'b1);
        send_byte(CYR_D1, 1'b0);
        send_byte(8'h85, 1'b1);
    endtask

    // Receiver held off while the sender keeps offering
    task automatic test_backpressure();
        int i;
        gaps_on = 1'b0;
        hold_request = 150;
        for (i = 0; i < 12; i++)
        begin
            send_byte(CYR_D0, 1'b0);
            send_byte(TAIL_SHCH, 1'b0);
        end
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_text();
        int          sent;
        int          kind;
        logic [7:0]  tail;
        logic        eot;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            eot = ($urandom_range(0, 15) == 0);
            if (sent % 100 < 3)
                gaps_on = 1'($urandom_range(0, 1));
            if (kind < 45)
            begin
                // well-formed letter
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_byte(CYR_D0, 1'b0);
                        tail = 8'($urandom_range(TAIL_D0_LO, TAIL_D0_HI));
                    end
                    1:
                    begin
                        send_byte(CYR_D1, 1'b0);
                        tail = 8'($urandom_range(TAIL_D1_LO, TAIL_D1_HI));
                    end
                    2:
                    begin
                        send_byte(CYR_D0, 1'b0);
                        tail = TAIL_YO_CAP;
                    end
                    default:
                    begin
                        send_byte(CYR_D1, 1'b0);
                        tail = TAIL_YO_SML;
                    end
                endcase
                send_byte(tail, eot);
                sent += 2;
            end
            else if (kind < 70)
            begin
                send_byte(8'($urandom_range(0, 127)), eot);
                sent++;
            end
            else if (kind < 82)
            begin
                send_byte(8'($urandom_range(0, 255)), eot);
                sent++;
            end
            else if (kind < 92)
            begin
                // broken sequence: lead then any byte
                send_byte($urandom_range(0, 1) ? CYR_D0 : CYR_D1, 1'b0);
                send_byte(8'($urandom_range(0, 255)), eot);
                sent += 2;
            end
            else if (kind < 97)
            begin
                send_byte($urandom_range(0, 1) ? CYR_D0 : CYR_D1, 1'b1);
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 1))
                    hold_request = $urandom_range(20, 60);
                wait_drain();
            end
        end
        gaps_on = 1'b1;
    endtask

    // Test sequence
    initial
    begin
        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        rst_n           = 1'b0;
        lead_state      = u2l_pkg::LEAD_NONE;
        error_count     = 0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        hold_request    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_letters();
        test_signs();
        test_raw_cases();
        wait_drain();
        test_backpressure();
        test_random_text();
        wait_drain();

        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d chars never came", expected_chars.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/u2l_pkg.sv
rtl/u2l_stream_if.sv
rtl/u2l_decode.sv
rtl/utf8_cyrillic_to_latin_top.sv
rtl/u2l_checker.sv
tb/testbench.sv
